[rtl/tpq_pkg.sv]
// Shared constants, codes, types and helper functions of the priority ticket queue.
package tpq_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int FIFO_DEPTH  = 64;
  localparam int NUM_LEVELS  = 3;

  localparam int TIDX_W     = $clog2(TABLE_DEPTH);
  localparam int FILL_W     = $clog2(TABLE_DEPTH + 1);
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int SLOT_DEPTH = NUM_LEVELS * FIFO_DEPTH;
  localparam int SADDR_W    = $clog2(SLOT_DEPTH);

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_ASSIGN   = 2'd1,
    OP_PROCESS  = 2'd2,
    OP_LOOKUP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_BAD_PRIO   = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_ALL_EMPTY  = 3'd5,
    ST_QUEUE_FULL = 3'd6
  } status_t;

  localparam logic [1:0] PRIO_HIGH    = 2'd0;
  localparam logic [1:0] PRIO_MEDIUM  = 2'd1;
  localparam logic [1:0] PRIO_LOW     = 2'd2;
  localparam logic [1:0] PRIO_INVALID = 2'd3;

  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  prio;
    logic [31:0] arrival;
  } ticket_t;

  localparam int TICKET_W = $bits(ticket_t);

  // Address of a position inside one level's region of the slot memory.
  function automatic logic [SADDR_W-1:0] slot_addr(input logic [1:0] lv,
                                                   input logic [FPTR_W-1:0] pos);
    logic [SADDR_W-1:0] base;
    begin
      case (lv)
        PRIO_HIGH:   base = '0;
        PRIO_MEDIUM: base = SADDR_W'(FIFO_DEPTH);
        default:     base = SADDR_W'(2 * FIFO_DEPTH);
      endcase
      return base + SADDR_W'(pos);
    end
  endfunction

  // Tail position of a ring that is not full: head plus count, wrapped once.
  function automatic logic [FPTR_W-1:0] fifo_pos(input logic [FPTR_W-1:0] head,
                                                 input logic [FCNT_W-1:0] cnt);
    logic [FCNT_W:0] sum;
    begin
      sum = (FCNT_W + 1)'(head) + (FCNT_W + 1)'(cnt);
      if (sum >= (FCNT_W + 1)'(FIFO_DEPTH)) begin
        sum = sum - (FCNT_W + 1)'(FIFO_DEPTH);
      end
      return sum[FPTR_W-1:0];
    end
  endfunction

endpackage

[rtl/tpq_if.sv]
// Request and response channel interfaces of the priority ticket queue.
interface tpq_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic signed [31:0] ticket_id;
  logic [1:0]        new_priority;
  logic [31:0]       arrival_time;

  modport source (output valid, output op, output ticket_id, output new_priority,
                  output arrival_time, input ready);
  modport sink   (input valid, input op, input ticket_id, input new_priority,
                  input arrival_time, output ready);
endinterface

interface tpq_rsp_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic signed [31:0] out_id;
  logic [1:0]        out_priority;
  logic [31:0]       out_time;

  modport source (output valid, output status, output out_id, output out_priority,
                  output out_time, input ready);
  modport sink   (input valid, input status, input out_id, input out_priority,
                  input out_time, output ready);
endinterface

[rtl/tpq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module tpq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/three_level_priority_ticket_queue_top.sv]
// Top level of the three-level priority ticket queue: sequencer, level pointers and memories.
//
//   channel  direction  handshake     word
//   req      in         valid/ready   op, ticket_id, new_priority, arrival_time
//   rsp      out        valid/ready   status, out_id, out_priority, out_time
//
// Register, assign and lookup scan the ticket memory one entry per cycle, up to the
// table fill (at most TABLE_DEPTH entries); process reads the slot memory, then the
// ticket memory, and skips both reads when all levels are empty.
// One request is worked on at a time; the next is taken once its result sits in the
// response register, even while that word is still stalled.
// Reset is synchronous and needs no clearing pass: the table fills in order, so the
// fill count alone tells which entries are valid.
module three_level_priority_ticket_queue_top (
  input  logic clk,
  input  logic rst,
  tpq_req_if.sink   req,
  tpq_rsp_if.source rsp
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SEARCH   = 7'b0000010,
    S_ACT      = 7'b0000100,
    S_POP      = 7'b0001000,
    S_POP_SLOT = 7'b0010000,
    S_POP_TBL  = 7'b0100000,
    S_RESULT   = 7'b1000000
  } state_t;

  state_t state;

  tpq_pkg::op_t       op_q;
  logic [31:0]        id_q;
  logic [1:0]         prio_q;
  logic [31:0]        time_q;

  logic [tpq_pkg::FILL_W-1:0] fill;
  logic [tpq_pkg::FPTR_W-1:0] heads  [tpq_pkg::NUM_LEVELS];
  logic [tpq_pkg::FCNT_W-1:0] counts [tpq_pkg::NUM_LEVELS];

  logic [tpq_pkg::FILL_W-1:0] issue_idx;
  logic                       rd_pend;
  logic [tpq_pkg::TIDX_W-1:0] rd_idx;
  logic                       found;
  logic [tpq_pkg::TIDX_W-1:0] hit_slot;
  tpq_pkg::ticket_t           hit;

  tpq_pkg::status_t res_status;
  tpq_pkg::ticket_t res_ticket;
  logic             out_valid;
  tpq_pkg::status_t out_status;
  tpq_pkg::ticket_t out_ticket;

  // Memory ports.
  logic                        t_we;
  logic [tpq_pkg::TIDX_W-1:0]  t_waddr;
  tpq_pkg::ticket_t            t_wdata;
  logic                        t_re;
  logic [tpq_pkg::TIDX_W-1:0]  t_raddr;
  tpq_pkg::ticket_t            t_rdata;
  logic                        s_we;
  logic [tpq_pkg::SADDR_W-1:0] s_waddr;
  logic [tpq_pkg::TIDX_W-1:0]  s_wdata;
  logic                        s_re;
  logic [tpq_pkg::SADDR_W-1:0] s_raddr;
  logic [tpq_pkg::TIDX_W-1:0]  s_rdata;

  logic                       in_fire;
  logic                       hit_now;
  logic                       search_miss;
  logic                       table_full;
  logic                       any_queued;
  logic [1:0]                 lv_sel;
  logic [tpq_pkg::FPTR_W-1:0] pop_head_next;
  logic [tpq_pkg::FPTR_W-1:0] tgt_head;
  logic [tpq_pkg::FCNT_W-1:0] tgt_cnt;
  logic                       tgt_full;

  assign req.ready = (state == S_IDLE);
  assign in_fire   = req.valid && req.ready;

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_id       = out_ticket.id;
  assign rsp.out_priority = out_ticket.prio;
  assign rsp.out_time     = out_ticket.arrival;

  assign hit_now     = rd_pend && (t_rdata.id == id_q);
  assign search_miss = !hit_now && (issue_idx >= fill);
  assign table_full  = (fill == tpq_pkg::FILL_W'(tpq_pkg::TABLE_DEPTH));
  assign tgt_full    = (tgt_cnt == tpq_pkg::FCNT_W'(tpq_pkg::FIFO_DEPTH));

  // Strict service order: the first non-empty level wins.
  always_comb begin
    any_queued = 1'b1;
    lv_sel     = tpq_pkg::PRIO_LOW;
    priority if (counts[0] != '0) begin
      lv_sel = tpq_pkg::PRIO_HIGH;
    end else if (counts[1] != '0) begin
      lv_sel = tpq_pkg::PRIO_MEDIUM;
    end else if (counts[2] != '0) begin
      lv_sel = tpq_pkg::PRIO_LOW;
    end else begin
      any_queued = 1'b0;
    end
  end

  assign pop_head_next = (heads[lv_sel] == tpq_pkg::FPTR_W'(tpq_pkg::FIFO_DEPTH - 1)) ?
                         '0 : heads[lv_sel] + tpq_pkg::FPTR_W'(1);

  always_comb begin
    case (prio_q)
      tpq_pkg::PRIO_HIGH: begin
        tgt_head = heads[0];
        tgt_cnt  = counts[0];
      end
      tpq_pkg::PRIO_MEDIUM: begin
        tgt_head = heads[1];
        tgt_cnt  = counts[1];
      end
      tpq_pkg::PRIO_LOW: begin
        tgt_head = heads[2];
        tgt_cnt  = counts[2];
      end
      default: begin
        tgt_head = '0;
        tgt_cnt  = '0;
      end
    endcase
  end

  // Memory access control.
  always_comb begin
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    t_re    = 1'b0;
    t_raddr = '0;
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_re    = 1'b0;
    s_raddr = '0;
    unique case (state)
      S_SEARCH: begin
        t_re    = !hit_now && (issue_idx < fill);
        t_raddr = issue_idx[tpq_pkg::TIDX_W-1:0];
      end
      S_ACT: begin
        if (op_q == tpq_pkg::OP_REGISTER) begin
          if (!found && !table_full) begin
            t_we    = 1'b1;
            t_waddr = fill[tpq_pkg::TIDX_W-1:0];
            t_wdata = '{id: id_q, prio: tpq_pkg::PRIO_LOW, arrival: time_q};
          end
        end else if (op_q == tpq_pkg::OP_ASSIGN) begin
          if (found) begin
            // The new code is stored even when nothing gets queued.
            t_we    = 1'b1;
            t_waddr = hit_slot;
            t_wdata = '{id: hit.id, prio: prio_q, arrival: hit.arrival};
            if (prio_q != tpq_pkg::PRIO_INVALID && !tgt_full) begin
              s_we    = 1'b1;
              s_waddr = tpq_pkg::slot_addr(prio_q, tpq_pkg::fifo_pos(tgt_head, tgt_cnt));
              s_wdata = hit_slot;
            end
          end
        end
      end
      S_POP: begin
        s_re    = any_queued;
        s_raddr = tpq_pkg::slot_addr(lv_sel, heads[lv_sel]);
      end
      S_POP_SLOT: begin
        t_re    = 1'b1;
        t_raddr = s_rdata;
      end
      S_IDLE, S_POP_TBL, S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      for (int i = 0; i < tpq_pkg::NUM_LEVELS; i++) begin
        heads[i]  <= '0;
        counts[i] <= '0;
      end
    end else begin
      // In the result state the response register is refilled instead of cleared.
      if (out_valid && rsp.ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            op_q      <= tpq_pkg::op_t'(req.op);
            id_q      <= req.ticket_id;
            prio_q    <= req.new_priority;
            time_q    <= req.arrival_time;
            issue_idx <= '0;
            rd_pend   <= 1'b0;
            found     <= 1'b0;
            state     <= (tpq_pkg::op_t'(req.op) == tpq_pkg::OP_PROCESS) ? S_POP : S_SEARCH;
          end
        end
        S_SEARCH: begin
          // One entry is read per cycle; its id is compared in the next one.
          rd_pend <= t_re;
          rd_idx  <= issue_idx[tpq_pkg::TIDX_W-1:0];
          if (t_re) begin
            issue_idx <= issue_idx + tpq_pkg::FILL_W'(1);
          end
          if (hit_now) begin
            found    <= 1'b1;
            hit_slot <= rd_idx;
            hit      <= t_rdata;
            state    <= S_ACT;
          end else if (search_miss) begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          res_ticket <= (op_q == tpq_pkg::OP_LOOKUP && found) ? hit : tpq_pkg::ticket_t'('0);
          state      <= S_RESULT;
          case (op_q)
            tpq_pkg::OP_REGISTER: begin
              if (found) begin
                res_status <= tpq_pkg::ST_DUPLICATE;
              end else if (table_full) begin
                res_status <= tpq_pkg::ST_TABLE_FULL;
              end else begin
                fill       <= fill + tpq_pkg::FILL_W'(1);
                res_status <= tpq_pkg::ST_OK;
              end
            end
            tpq_pkg::OP_ASSIGN: begin
              if (!found) begin
                res_status <= tpq_pkg::ST_NOT_FOUND;
              end else if (prio_q == tpq_pkg::PRIO_INVALID) begin
                res_status <= tpq_pkg::ST_BAD_PRIO;
              end else if (tgt_full) begin
                res_status <= tpq_pkg::ST_QUEUE_FULL;
              end else begin
                counts[prio_q] <= tgt_cnt + tpq_pkg::FCNT_W'(1);
                res_status     <= tpq_pkg::ST_OK;
              end
            end
            tpq_pkg::OP_LOOKUP: begin
              if (found) begin
                res_status <= tpq_pkg::ST_OK;
              end else begin
                res_status <= tpq_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              res_status <= tpq_pkg::ST_ALL_EMPTY;
            end
          endcase
        end
        S_POP: begin
          if (any_queued) begin
            heads[lv_sel]  <= pop_head_next;
            counts[lv_sel] <= counts[lv_sel] - tpq_pkg::FCNT_W'(1);
            state          <= S_POP_SLOT;
          end else begin
            res_status <= tpq_pkg::ST_ALL_EMPTY;
            res_ticket <= '0;
            state      <= S_RESULT;
          end
        end
        S_POP_SLOT: begin
          state <= S_POP_TBL;
        end
        S_POP_TBL: begin
          // The ticket reports its current stored priority, not the level it left.
          res_status <= tpq_pkg::ST_OK;
          res_ticket <= t_rdata;
          state      <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_ticket <= res_ticket;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tpq_ram #(
    .Width (tpq_pkg::TICKET_W),
    .Depth (tpq_pkg::TABLE_DEPTH)
  ) u_ticket_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  tpq_ram #(
    .Width (tpq_pkg::TIDX_W),
    .Depth (tpq_pkg::SLOT_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= tpq_pkg::FILL_W'(tpq_pkg::TABLE_DEPTH))
    else $error("ticket table fill count went past the table depth");

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> fill >= $past(fill))
    else $error("ticket table fill count went down");

  a_counts_bound: assert property (@(posedge clk) disable iff (rst)
    counts[0] <= tpq_pkg::FCNT_W'(tpq_pkg::FIFO_DEPTH) &&
    counts[1] <= tpq_pkg::FCNT_W'(tpq_pkg::FIFO_DEPTH) &&
    counts[2] <= tpq_pkg::FCNT_W'(tpq_pkg::FIFO_DEPTH))
    else $error("a level queue holds more words than its depth");

  a_pop_read: assert property (@(posedge clk) disable iff (rst)
    state == S_POP_SLOT |-> $past(s_re))
    else $error("slot data used without a slot memory read");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESULT))
    else $error("response word loaded outside the result state");

endmodule
